// ===== design/bis_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
`timescale 1ns / 1ps

package bis_pkg;

  localparam int CoordW    = 8;
  localparam int PixelW    = 24;
  localparam int ChanW     = 8;
  localparam int NumChan   = 3;
  localparam int DimW      = 9;
  localparam int FracW     = 8;
  localparam int IncW      = DimW + FracW;
  localparam int DivSteps  = IncW;
  localparam int CfgIdxW   = 4;
  localparam int DimReset  = 256;

  localparam logic [CfgIdxW-1:0] CfgSourceWidth  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSourceHeight = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetWidth  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgTargetHeight = 4'd3;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_e;

  typedef enum logic [1:0] {
    NBR_00 = 2'd0,
    NBR_01 = 2'd1,
    NBR_10 = 2'd2,
    NBR_11 = 2'd3
  } nbr_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_X,
    S_LOAD_Y,
    S_DIV_Y,
    S_STORE_Y,
    S_POS,
    S_NBR,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD_WAIT,
    S_BLEND_TOP,
    S_BLEND_OUT,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    op_e               op;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [PixelW-1:0] source_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] scaled_pixel;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  store;
    logic  div_load;
    logic  div_step;
    axis_e div_axis;
    logic  inc_store_x;
    logic  inc_store_y;
    logic  pos_calc;
    logic  nbr_calc;
    nbr_e  rd_sel;
    logic  pix_cap;
    nbr_e  pix_sel;
    logic  blend_top;
    logic  blend_out;
    logic  res_oor;
  } cmd_t;

  typedef struct packed {
    logic oor;
  } status_t;

endpackage

// ===== design/bis_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bis_ctrl.sv =====
// Controller state machine that issues load writes and sequences sample transactions.
`timescale 1ns / 1ps

module bis_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bis_pkg::op_e       op_i,
  input  bis_pkg::status_t   status_i,
  output bis_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               result_valid_o
);

  localparam int CntW = $clog2(bis_pkg::DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(bis_pkg::DivSteps - 1);

  bis_pkg::ctl_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  bis_pkg::cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bis_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      bis_pkg::S_IDLE: begin
        if (start_i) begin
          if (op_i == bis_pkg::OP_SAMPLE) begin
            cmd.capture = 1'b1;
            state_d     = bis_pkg::S_CHECK;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      bis_pkg::S_CHECK: begin
        if (status_i.oor) begin
          cmd.res_oor = 1'b1;
          state_d     = bis_pkg::S_OUT;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_axis = bis_pkg::AXIS_X;
          cnt_d        = '0;
          state_d      = bis_pkg::S_DIV_X;
        end
      end
      bis_pkg::S_DIV_X: begin
        cmd.div_step = 1'b1;
        cmd.div_axis = bis_pkg::AXIS_X;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = bis_pkg::S_LOAD_Y;
        end
      end
      bis_pkg::S_LOAD_Y: begin
        cmd.inc_store_x = 1'b1;
        cmd.div_load    = 1'b1;
        cmd.div_axis    = bis_pkg::AXIS_Y;
        cnt_d           = '0;
        state_d         = bis_pkg::S_DIV_Y;
      end
      bis_pkg::S_DIV_Y: begin
        cmd.div_step = 1'b1;
        cmd.div_axis = bis_pkg::AXIS_Y;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = bis_pkg::S_STORE_Y;
        end
      end
      bis_pkg::S_STORE_Y: begin
        cmd.inc_store_y = 1'b1;
        state_d         = bis_pkg::S_POS;
      end
      bis_pkg::S_POS: begin
        cmd.pos_calc = 1'b1;
        state_d      = bis_pkg::S_NBR;
      end
      bis_pkg::S_NBR: begin
        cmd.nbr_calc = 1'b1;
        state_d      = bis_pkg::S_RD0;
      end
      bis_pkg::S_RD0: begin
        cmd.rd_sel = bis_pkg::NBR_00;
        state_d    = bis_pkg::S_RD1;
      end
      bis_pkg::S_RD1: begin
        cmd.rd_sel  = bis_pkg::NBR_01;
        cmd.pix_cap = 1'b1;
        cmd.pix_sel = bis_pkg::NBR_00;
        state_d     = bis_pkg::S_RD2;
      end
      bis_pkg::S_RD2: begin
        cmd.rd_sel  = bis_pkg::NBR_10;
        cmd.pix_cap = 1'b1;
        cmd.pix_sel = bis_pkg::NBR_01;
        state_d     = bis_pkg::S_RD3;
      end
      bis_pkg::S_RD3: begin
        cmd.rd_sel  = bis_pkg::NBR_11;
        cmd.pix_cap = 1'b1;
        cmd.pix_sel = bis_pkg::NBR_10;
        state_d     = bis_pkg::S_RD_WAIT;
      end
      bis_pkg::S_RD_WAIT: begin
        cmd.pix_cap = 1'b1;
        cmd.pix_sel = bis_pkg::NBR_11;
        state_d     = bis_pkg::S_BLEND_TOP;
      end
      bis_pkg::S_BLEND_TOP: begin
        cmd.blend_top = 1'b1;
        state_d       = bis_pkg::S_BLEND_OUT;
      end
      bis_pkg::S_BLEND_OUT: begin
        cmd.blend_out = 1'b1;
        state_d       = bis_pkg::S_OUT;
      end
      bis_pkg::S_OUT: begin
        state_d = bis_pkg::S_IDLE;
      end
      default: begin
        state_d = bis_pkg::S_IDLE;
      end
    endcase
  end

  assign cmd_o          = cmd;
  assign busy_o         = (state_q != bis_pkg::S_IDLE);
  assign result_valid_o = (state_q == bis_pkg::S_OUT);

  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == bis_pkg::OP_SAMPLE) |=> busy_o)
    else $error("sample transaction accepted without going busy");

  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> (!busy_o && start_i && op_i == bis_pkg::OP_LOAD))
    else $error("store write issued outside an accepted load");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bis_pkg::S_DIV_X || state_q == bis_pkg::S_DIV_Y) |-> cnt_q <= CntLast)
    else $error("divider step count overran");

endmodule

// ===== design/bis_datapath.sv =====
// Datapath: configuration, step divider, position, frame store and blend.
`timescale 1ns / 1ps

module bis_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bis_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bis_pkg::DimW-1:0]       cfg_data_i,
  input  bis_pkg::in_item_t              in_item_i,
  input  bis_pkg::cmd_t                  cmd_i,
  output bis_pkg::status_t               status_o,
  output bis_pkg::out_item_t             out_item_o
);

  localparam int DimW    = bis_pkg::DimW;
  localparam int FracW   = bis_pkg::FracW;
  localparam int IncW    = bis_pkg::IncW;
  localparam int CoordW  = bis_pkg::CoordW;
  localparam int ChanW   = bis_pkg::ChanW;
  localparam int ProdW   = IncW + CoordW;
  localparam int PosW    = ProdW + 1;
  localparam int IdxW    = PosW - FracW;
  localparam int MixW    = 2 * ChanW;
  localparam int SumW    = 3 * ChanW;
  localparam int Depth   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(Depth);
  localparam int MaxDim  = 2 ** DimW - 1;
  localparam logic [DimW-1:0] MaxW = (MAX_WIDTH > MaxDim) ? DimW'(MaxDim) : DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] MaxH =
    (MAX_HEIGHT > MaxDim) ? DimW'(MaxDim) : DimW'(MAX_HEIGHT);
  localparam logic [ChanW-1:0] ChanMax = '1;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [DimW-1:0] y,
                                            input logic [DimW-1:0] x);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  function automatic logic [DimW-1:0] clamp_idx(input logic [IdxW-1:0] v,
                                                input logic [DimW-1:0] last);
    logic [DimW-1:0] r;
    if (v > IdxW'(last)) begin
      r = last;
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  logic [DimW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [DimW-1:0] sw, sh, tw, th;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DimW'(bis_pkg::DimReset);
      src_h_q <= DimW'(bis_pkg::DimReset);
      tgt_w_q <= DimW'(bis_pkg::DimReset);
      tgt_h_q <= DimW'(bis_pkg::DimReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bis_pkg::CfgSourceWidth:  src_w_q <= cfg_data_i;
        bis_pkg::CfgSourceHeight: src_h_q <= cfg_data_i;
        bis_pkg::CfgTargetWidth:  tgt_w_q <= cfg_data_i;
        bis_pkg::CfgTargetHeight: tgt_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw = clamp_dim(src_w_q, MaxW);
  assign sh = clamp_dim(src_h_q, MaxH);
  assign tw = clamp_dim(tgt_w_q, MaxW);
  assign th = clamp_dim(tgt_h_q, MaxH);

  logic [CoordW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q <= in_item_i.coord_x;
      cy_q <= in_item_i.coord_y;
    end
  end

  assign status_o.oor = ({1'b0, cx_q} >= tw) || ({1'b0, cy_q} >= th);

  // Restoring divider, one quotient bit per step.
  logic [IncW-1:0] quo_q, quo_d;
  logic [DimW-1:0] rem_q, rem_d;
  logic [DimW-1:0] divisor;
  logic [DimW:0]   rem_shift;

  assign divisor   = (cmd_i.div_axis == bis_pkg::AXIS_Y) ? th : tw;
  assign rem_shift = {rem_q, quo_q[IncW-1]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.div_load) begin
      rem_d = '0;
      quo_d = (cmd_i.div_axis == bis_pkg::AXIS_Y) ? {sh, {FracW{1'b0}}} : {sw, {FracW{1'b0}}};
    end else if (cmd_i.div_step) begin
      if (rem_shift >= {1'b0, divisor}) begin
        rem_d = DimW'(rem_shift - {1'b0, divisor});
        quo_d = {quo_q[IncW-2:0], 1'b1};
      end else begin
        rem_d = DimW'(rem_shift);
        quo_d = {quo_q[IncW-2:0], 1'b0};
      end
    end
  end

  logic [IncW-1:0] xinc_q, yinc_q;

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.inc_store_x) begin
      xinc_q <= quo_q;
    end
    if (cmd_i.inc_store_y) begin
      yinc_q <= quo_q;
    end
  end

  logic [PosW-1:0] pos_x_q, pos_y_q;
  logic [ProdW-1:0] prod_x, prod_y;

  assign prod_x = ProdW'(xinc_q) * ProdW'(cx_q);
  assign prod_y = ProdW'(yinc_q) * ProdW'(cy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_calc) begin
      pos_x_q <= PosW'(prod_x) + PosW'(xinc_q >> 1);
      pos_y_q <= PosW'(prod_y) + PosW'(yinc_q >> 1);
    end
  end

  logic [DimW-1:0]  last_x, last_y, px0, py0;
  logic [DimW-1:0]  px0_q, px1_q, py0_q, py1_q;
  logic [ChanW-1:0] fx_q, fy_q;

  assign last_x = sw - 1'b1;
  assign last_y = sh - 1'b1;
  assign px0    = clamp_idx(pos_x_q[PosW-1:FracW], last_x);
  assign py0    = clamp_idx(pos_y_q[PosW-1:FracW], last_y);

  always_ff @(posedge clk_i) begin
    if (cmd_i.nbr_calc) begin
      px0_q <= px0;
      py0_q <= py0;
      px1_q <= (px0 == last_x) ? last_x : px0 + 1'b1;
      py1_q <= (py0 == last_y) ? last_y : py0 + 1'b1;
      fx_q  <= pos_x_q[FracW-1:0];
      fy_q  <= pos_y_q[FracW-1:0];
    end
  end

  logic [AW-1:0]              raddr, waddr;
  logic [bis_pkg::PixelW-1:0] rdata;
  logic                       store_we;

  always_comb begin
    case (cmd_i.rd_sel)
      bis_pkg::NBR_00: raddr = addr_of(py0_q, px0_q);
      bis_pkg::NBR_01: raddr = addr_of(py0_q, px1_q);
      bis_pkg::NBR_10: raddr = addr_of(py1_q, px0_q);
      bis_pkg::NBR_11: raddr = addr_of(py1_q, px1_q);
      default:         raddr = addr_of(py0_q, px0_q);
    endcase
  end

  assign waddr    = addr_of(DimW'(in_item_i.coord_y), DimW'(in_item_i.coord_x));
  assign store_we = cmd_i.store && (int'(in_item_i.coord_x) < MAX_WIDTH) &&
                    (int'(in_item_i.coord_y) < MAX_HEIGHT);

  bis_ram #(
    .WIDTH (bis_pkg::PixelW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.source_pixel),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [bis_pkg::PixelW-1:0] pix_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_cap) begin
      pix_q[cmd_i.pix_sel] <= rdata;
    end
  end

  logic [ChanW-1:0] fxn, fyn;
  logic [MixW-1:0]  top_q [bis_pkg::NumChan];
  logic [MixW-1:0]  bot_q [bis_pkg::NumChan];
  logic [MixW-1:0]  top_d [bis_pkg::NumChan];
  logic [MixW-1:0]  bot_d [bis_pkg::NumChan];
  logic [SumW-1:0]  mix   [bis_pkg::NumChan];

  assign fxn = ChanMax - fx_q;
  assign fyn = ChanMax - fy_q;

  always_comb begin
    for (int c = 0; c < bis_pkg::NumChan; c++) begin
      top_d[c] = MixW'(pix_q[bis_pkg::NBR_00][c*ChanW +: ChanW]) * MixW'(fxn) +
                 MixW'(pix_q[bis_pkg::NBR_01][c*ChanW +: ChanW]) * MixW'(fx_q);
      bot_d[c] = MixW'(pix_q[bis_pkg::NBR_10][c*ChanW +: ChanW]) * MixW'(fxn) +
                 MixW'(pix_q[bis_pkg::NBR_11][c*ChanW +: ChanW]) * MixW'(fx_q);
      mix[c]   = SumW'(top_q[c]) * SumW'(fyn) + SumW'(bot_q[c]) * SumW'(fy_q);
    end
  end

  bis_pkg::out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_top) begin
      for (int c = 0; c < bis_pkg::NumChan; c++) begin
        top_q[c] <= top_d[c];
        bot_q[c] <= bot_d[c];
      end
    end
    if (cmd_i.res_oor) begin
      res_q.scaled_pixel <= '0;
      res_q.out_of_range <= 1'b1;
    end else if (cmd_i.blend_out) begin
      for (int c = 0; c < bis_pkg::NumChan; c++) begin
        res_q.scaled_pixel[c*ChanW +: ChanW] <= mix[c][SumW-1 -: ChanW];
      end
      res_q.out_of_range <= 1'b0;
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== design/bilinear_image_scaler.sv =====
// Top level of the bilinear image scaler: controller, datapath and ports.
`timescale 1ns / 1ps

// The block scales an RGB source image held in an internal frame store.
// A transaction is accepted at a clock edge with start_i high and busy_o low.
// A load transaction (op load) writes source_pixel at coord_x, coord_y and
// leaves busy_o low, so loads may be issued every cycle.
// A sample transaction (op sample) names a target pixel and raises busy_o.
// Its result is held on out_item_o and marked by result_valid_o for exactly
// one cycle; the next transaction can be accepted in the cycle after that
// strobe. The sample time is set by the restoring divider, which takes
// 17 steps per axis to form the 9.8 step, and by the four reads of the
// single read port of the store.
// A sample outside the target size returns out_of_range with zero pixel data.
// The configuration port writes dimension registers by index with cfg_we_i.
// Write only while no sample is in flight: the block does not enforce this.
// Reset returns the controller to idle and all dimensions to 256; the frame
// store is not cleared and must be loaded before it is sampled.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  bis_pkg::in_item_t           in_item_i,
  output logic                        result_valid_o,
  output bis_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [bis_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bis_pkg::DimW-1:0]    cfg_data_i
);

  bis_pkg::cmd_t    cmd;
  bis_pkg::status_t status;

  bis_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (in_item_i.op),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  bis_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the bilinear image scaler with a built-in predictor.
`timescale 1ns / 1ps

module tb;

  localparam int CoordW       = bis_pkg::CoordW;
  localparam int PixelW       = bis_pkg::PixelW;
  localparam int ChanW        = bis_pkg::ChanW;
  localparam int NumChan      = bis_pkg::NumChan;
  localparam int DimW         = bis_pkg::DimW;
  localparam int CfgIdxW      = bis_pkg::CfgIdxW;
  localparam int MaxW         = 256;
  localparam int MaxH         = 256;
  localparam int SettleCycles = 64;
  localparam int IdleLimit    = 2000;
  localparam int PhaseCount   = 12;
  localparam int PhaseXacts   = 100;

  localparam logic [CfgIdxW-1:0] CfgUnused = 4'd15;

  typedef enum logic {
    ROW_REG,
    ROW_XACT
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [DimW-1:0]    reg_data;
    bis_pkg::in_item_t  item;
    logic               typed;
    bis_pkg::out_item_t want;
  } dir_row_t;

  localparam bis_pkg::out_item_t NoWant  = '0;
  localparam bis_pkg::out_item_t OorWant = '{scaled_pixel: '0, out_of_range: 1'b1};

  localparam int DirRows = 34;
  localparam dir_row_t DirTable [DirRows] = '{
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd0, 8'd0, 24'hFFFFFF}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd1, 8'd0, 24'h000000}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd0, 8'd1, 24'hAAAAAA}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd1, 8'd1, 24'h555555}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd0, 24'h0}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd255, 8'd255, 24'hFFFFFF}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd255, 8'd255, 24'h0}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_LOAD, 8'd255, 8'd0, 24'h123456}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd255, 8'd0, 24'h0}, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetWidth, 9'd16, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetHeight, 9'd8, '0, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd16, 8'd0, 24'hFFFFFF}, 1'b1, OorWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd8, 24'h0}, 1'b1, OorWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd255, 8'd255, 24'h0}, 1'b1, OorWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd15, 8'd7, 24'h0}, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgSourceWidth, 9'd0, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgSourceHeight, 9'd511, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetWidth, 9'd511, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetHeight, 9'd0, '0, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd0, 24'h0}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd200, 8'd0, 24'h0}, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd1, 24'h0}, 1'b1, OorWant},
    '{ROW_REG, CfgUnused, 9'd3, '0, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd1, 24'h0}, 1'b1, OorWant},
    '{ROW_REG, bis_pkg::CfgSourceWidth, 9'd1, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgSourceHeight, 9'd1, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetWidth, 9'd256, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetHeight, 9'd256, '0, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd255, 8'd255, 24'h0}, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgSourceWidth, 9'd256, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgSourceHeight, 9'd256, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetWidth, 9'd1, '0, 1'b0, NoWant},
    '{ROW_REG, bis_pkg::CfgTargetHeight, 9'd1, '0, 1'b0, NoWant},
    '{ROW_XACT, 4'd0, 9'd0, '{bis_pkg::OP_SAMPLE, 8'd0, 8'd0, 24'h0}, 1'b0, NoWant}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  bis_pkg::in_item_t  in_item_i;
  logic               result_valid_o;
  bis_pkg::out_item_t out_item_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DimW-1:0]    cfg_data_i;

  logic [DimW-1:0]    src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [PixelW-1:0]  frame_mem [MaxW*MaxH];
  bit                 frame_seen [MaxW*MaxH];
  bis_pkg::out_item_t pending_q [$];
  bit                 failed;
  bit                 no_gaps;
  int                 xact_cnt;
  int                 idle_cycles;

  bilinear_image_scaler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_item_i      (in_item_i),
    .result_valid_o (result_valid_o),
    .out_item_o     (out_item_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int unsigned fit_dim(logic [DimW-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void locate(input int unsigned coord, input int unsigned src,
                                 input int unsigned tgt, output int unsigned lo,
                                 output int unsigned hi, output int unsigned frac);
    int unsigned inc;
    int unsigned pos;
    inc  = (src << 8) / tgt;
    pos  = inc / 2 + coord * inc;
    lo   = pos >> 8;
    if (lo > src - 1) lo = src - 1;
    hi   = (lo + 1 > src - 1) ? src - 1 : lo + 1;
    frac = pos & 255;
  endfunction

  function automatic bit in_target(logic [CoordW-1:0] cx, logic [CoordW-1:0] cy);
    return cx < fit_dim(tgt_w_q, MaxW) && cy < fit_dim(tgt_h_q, MaxH);
  endfunction

  function automatic bis_pkg::out_item_t scale_sample(logic [CoordW-1:0] cx,
                                                      logic [CoordW-1:0] cy);
    int unsigned sw, sh, tw, th;
    int unsigned x0, x1, y0, y1, fx, fy;
    int unsigned top, bot;
    logic [PixelW-1:0] p00, p01, p10, p11;
    bis_pkg::out_item_t res;
    res = '0;
    if (!in_target(cx, cy)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    sw = fit_dim(src_w_q, MaxW);
    sh = fit_dim(src_h_q, MaxH);
    tw = fit_dim(tgt_w_q, MaxW);
    th = fit_dim(tgt_h_q, MaxH);
    locate(cx, sw, tw, x0, x1, fx);
    locate(cy, sh, th, y0, y1, fy);
    p00 = frame_mem[y0 * MaxW + x0];
    p01 = frame_mem[y0 * MaxW + x1];
    p10 = frame_mem[y1 * MaxW + x0];
    p11 = frame_mem[y1 * MaxW + x1];
    for (int ch = 0; ch < NumChan; ch++) begin
      top = int'(p00[ch*ChanW +: ChanW]) * (255 - fx) + int'(p01[ch*ChanW +: ChanW]) * fx;
      bot = int'(p10[ch*ChanW +: ChanW]) * (255 - fx) + int'(p11[ch*ChanW +: ChanW]) * fx;
      res.scaled_pixel[ch*ChanW +: ChanW] = ChanW'((top * (255 - fy) + bot * fy) >> 16);
    end
    return res;
  endfunction

  function automatic logic [PixelW-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PixelW'($urandom);
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic push_xact(input bis_pkg::in_item_t item, input bit typed,
                           input bis_pkg::out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   = 1'b1;
    in_item_i = item;
    do @(posedge clk_i); while (busy_o);
    if (item.op == bis_pkg::OP_LOAD) begin
      frame_mem[item.coord_y * MaxW + item.coord_x]  = item.source_pixel;
      frame_seen[item.coord_y * MaxW + item.coord_x] = 1'b1;
    end else begin
      pending_q.push_back(typed ? want : scale_sample(item.coord_x, item.coord_y));
    end
    xact_cnt++;
    @(negedge clk_i);
  endtask

  // Loads any neighbor that a sample would read before it was written.
  task automatic issue_sample(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                              input bit typed, input bis_pkg::out_item_t want);
    int unsigned xs [2];
    int unsigned ys [2];
    int unsigned fx, fy;
    bis_pkg::in_item_t item;
    if (in_target(cx, cy)) begin
      locate(cx, fit_dim(src_w_q, MaxW), fit_dim(tgt_w_q, MaxW), xs[0], xs[1], fx);
      locate(cy, fit_dim(src_h_q, MaxH), fit_dim(tgt_h_q, MaxH), ys[0], ys[1], fy);
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          if (!frame_seen[ys[j] * MaxW + xs[i]]) begin
            item = '{bis_pkg::OP_LOAD, CoordW'(xs[i]), CoordW'(ys[j]), rand_pixel()};
            push_xact(item, 1'b0, NoWant);
          end
        end
      end
    end
    item = '{bis_pkg::OP_SAMPLE, cx, cy, rand_pixel()};
    push_xact(item, typed, want);
  endtask

  task automatic settle();
    start_i = 1'b0;
    while (pending_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    case (idx)
      bis_pkg::CfgSourceWidth:  src_w_q = data;
      bis_pkg::CfgSourceHeight: src_h_q = data;
      bis_pkg::CfgTargetWidth:  tgt_w_q = data;
      bis_pkg::CfgTargetHeight: tgt_h_q = data;
      default: ;
    endcase
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 9'd0;
    if (r == 1) return 9'd1;
    if (r == 2) return 9'd256;
    if (r == 3) return DimW'($urandom_range(257, 511));
    return DimW'($urandom_range(1, 256));
  endfunction

  function automatic logic [CoordW-1:0] pick_coord(int unsigned dim);
    if ($urandom_range(0, 9) < 8) return CoordW'($urandom_range(0, dim - 1));
    return CoordW'($urandom);
  endfunction

  always @(posedge clk_i) begin
    bis_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (result_valid_o) begin
        if (pending_q.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result, expected none, got pixel %h oor %b",
                   $realtime, out_item_o.scaled_pixel, out_item_o.out_of_range);
        end else begin
          exp_item = pending_q.pop_front();
          if (out_item_o.scaled_pixel !== exp_item.scaled_pixel) begin
            failed = 1'b1;
            $display("%0t: scaled_pixel mismatch, expected %h, got %h",
                     $realtime, exp_item.scaled_pixel, out_item_o.scaled_pixel);
          end
          if (out_item_o.out_of_range !== exp_item.out_of_range) begin
            failed = 1'b1;
            $display("%0t: out_of_range mismatch, expected %b, got %b",
                     $realtime, exp_item.out_of_range, out_item_o.out_of_range);
          end
        end
      end
      if ((start_i && !busy_o) || result_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: watchdog expired", $realtime);
        $display("FAIL bilinear_image_scaler");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bis_pkg::in_item_t item;
    int unsigned phase_base;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    src_w_q    = DimW'(bis_pkg::DimReset);
    src_h_q    = DimW'(bis_pkg::DimReset);
    tgt_w_q    = DimW'(bis_pkg::DimReset);
    tgt_h_q    = DimW'(bis_pkg::DimReset);
    failed     = 1'b0;
    no_gaps    = 1'b0;
    xact_cnt   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (DirTable[r].kind == ROW_REG) begin
        settle();
        write_reg(DirTable[r].reg_idx, DirTable[r].reg_data);
      end else if (DirTable[r].item.op == bis_pkg::OP_LOAD) begin
        push_xact(DirTable[r].item, 1'b0, NoWant);
      end else begin
        issue_sample(DirTable[r].item.coord_x, DirTable[r].item.coord_y,
                     DirTable[r].typed, DirTable[r].want);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      write_reg(bis_pkg::CfgSourceWidth, pick_dim());
      write_reg(bis_pkg::CfgSourceHeight, pick_dim());
      write_reg(bis_pkg::CfgTargetWidth, pick_dim());
      write_reg(bis_pkg::CfgTargetHeight, pick_dim());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgIdxW'($urandom_range(4, 15)), DimW'($urandom));
      end
      no_gaps    = ($urandom_range(0, 3) == 0);
      phase_base = xact_cnt;
      while (xact_cnt - phase_base < PhaseXacts) begin
        if ($urandom_range(0, 9) < 4) begin
          item = '{bis_pkg::OP_LOAD, pick_coord(fit_dim(src_w_q, MaxW)),
                   pick_coord(fit_dim(src_h_q, MaxH)), rand_pixel()};
          push_xact(item, 1'b0, NoWant);
        end else begin
          issue_sample(pick_coord(fit_dim(tgt_w_q, MaxW)),
                       pick_coord(fit_dim(tgt_h_q, MaxH)), 1'b0, NoWant);
        end
      end
    end

    settle();
    if (pending_q.size() != 0) begin
      failed = 1'b1;
      $display("%0t: %0d expected results never arrived", $realtime, pending_q.size());
    end
    if (failed) begin
      $display("FAIL bilinear_image_scaler");
    end else begin
      $display("PASS bilinear_image_scaler");
    end
    $finish;
  end

endmodule

// ===== bilinear_image_scaler.f =====
design/bis_pkg.sv
design/bis_ram.sv
design/bis_ctrl.sv
design/bis_datapath.sv
design/bilinear_image_scaler.sv
tb/tb.sv
